// ===== rtl/pfbm_pkg.sv =====
package pfbm_pkg;

  localparam logic [2:0] ACT_FETCH  = 3'd0;
  localparam logic [2:0] ACT_UNPIN  = 3'd1;
  localparam logic [2:0] ACT_FLUSH  = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_NEW    = 3'd4;

  localparam int TAG_W   = 31;
  localparam int FRAME_W = 6;

  typedef struct packed {
    logic [2:0]       action;
    logic [TAG_W-1:0] page_id;
    logic             mark_dirty;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               write_back;
    logic [TAG_W-1:0]   write_back_page;
    logic               read_in;
    logic               deallocate;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_UNPIN,
    OP_FLUSH,
    OP_DELETE,
    OP_NEW,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] page_id;
    logic             mark_dirty;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLR,
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_UPD
  } bk_state_t;

  typedef enum logic [1:0] {
    AM_NONE,
    AM_DEC,
    AM_INC
  } age_mode_t;

endpackage

// ===== rtl/pfbm_ram.sv =====
module pfbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pfbm_front.sv =====
module pfbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pfbm_pkg::in_item_t  in_item,
  input  logic                clearing,
  output logic                q_valid,
  output pfbm_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);

  pfbm_pkg::cmd_t ent_r [2];
  logic           rd_ptr_r, rd_ptr_nxt;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  pfbm_pkg::cmd_t cls;
  logic           push;

  always_comb begin
    cls.page_id    = in_item.page_id;
    cls.mark_dirty = in_item.mark_dirty;
    unique case (in_item.action)
      pfbm_pkg::ACT_FETCH:  cls.op = pfbm_pkg::OP_FETCH;
      pfbm_pkg::ACT_UNPIN:  cls.op = pfbm_pkg::OP_UNPIN;
      pfbm_pkg::ACT_FLUSH:  cls.op = pfbm_pkg::OP_FLUSH;
      pfbm_pkg::ACT_DELETE: cls.op = pfbm_pkg::OP_DELETE;
      pfbm_pkg::ACT_NEW:    cls.op = pfbm_pkg::OP_NEW;
      default:              cls.op = pfbm_pkg::OP_NONE;
    endcase
  end

  assign busy    = (cnt_r == 2'd2) || clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (q_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/pfbm_back.sv =====
module pfbm_back #(
  parameter int NUM_FRAMES = 64,
  parameter int PIN_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  pfbm_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 out_valid,
  output pfbm_pkg::out_item_t  out_item
);

  localparam int FW = $clog2(NUM_FRAMES);
  localparam logic [FW:0]         NV   = (FW+1)'(NUM_FRAMES);
  localparam logic [FW-1:0]       LAST = FW'(NUM_FRAMES - 1);
  localparam logic [PIN_BITS-1:0] PMAX = {PIN_BITS{1'b1}};

  typedef struct packed {
    logic                       valid;
    logic [pfbm_pkg::TAG_W-1:0] tag;
    logic [PIN_BITS-1:0]        pin;
    logic                       dirty;
    logic                       evict;
    logic [FW-1:0]              age;
  } rec_t;

  localparam int RW = $bits(rec_t);

  pfbm_pkg::bk_state_t state_r, state_nxt;
  logic [FW:0]         cnt_r, cnt_nxt;
  logic                pv_r, pv_nxt;
  logic [FW-1:0]       pidx_r, pidx_nxt;
  pfbm_pkg::cmd_t      cmd_r, cmd_nxt;
  logic                hit_r, hit_nxt;
  logic [FW-1:0]       hf_r, hf_nxt;
  rec_t                hrec_r, hrec_nxt;
  logic                lv_r, lv_nxt;
  logic [FW-1:0]       lf_r, lf_nxt;
  rec_t                lrec_r, lrec_nxt;
  logic [FW-1:0]       head_r, head_nxt;
  logic [FW:0]         fcnt_r, fcnt_nxt;
  logic [FW-1:0]       tf_r, tf_nxt;
  rec_t                trec_r, trec_nxt;
  pfbm_pkg::age_mode_t mode_r, mode_nxt;
  logic [FW-1:0]       thr_r, thr_nxt;
  pfbm_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic          rec_we;
  logic [FW-1:0] rec_waddr;
  rec_t          rec_wdata;
  logic [RW-1:0] rec_rbits;
  rec_t          rec_rd;
  logic          fq_we;
  logic [FW-1:0] fq_waddr;
  logic [FW-1:0] fq_wdata;
  logic [FW-1:0] fq_rd;

  pfbm_ram #(.WIDTH(RW), .DEPTH(NUM_FRAMES)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (cnt_r[FW-1:0]),
    .rdata (rec_rbits)
  );

  pfbm_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_free_ram (
    .clk   (clk),
    .we    (fq_we),
    .waddr (fq_waddr),
    .wdata (fq_wdata),
    .raddr (head_r),
    .rdata (fq_rd)
  );

  assign rec_rd    = rec_t'(rec_rbits);
  assign clearing  = (state_r == pfbm_pkg::BK_CLR);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  function automatic logic [pfbm_pkg::FRAME_W-1:0] to_frame(input logic [FW-1:0] f);
    logic [FW+pfbm_pkg::FRAME_W-1:0] w;
    w = {{pfbm_pkg::FRAME_W{1'b0}}, f};
    return w[pfbm_pkg::FRAME_W-1:0];
  endfunction

  always_comb begin
    pfbm_pkg::out_item_t res;
    rec_t                tgt;
    rec_t                inst;
    rec_t                upd;
    logic                wr;
    logic                pop;
    logic                push;
    logic                have_free;
    logic                vok;
    logic                vwb;
    logic [FW-1:0]       vf;
    logic [FW-1:0]       tfr;
    logic [FW:0]         tail;
    pfbm_pkg::age_mode_t md;
    logic [FW-1:0]       thr;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = cnt_r[FW-1:0];
    cmd_nxt       = cmd_r;
    hit_nxt       = hit_r;
    hf_nxt        = hf_r;
    hrec_nxt      = hrec_r;
    lv_nxt        = lv_r;
    lf_nxt        = lf_r;
    lrec_nxt      = lrec_r;
    head_nxt      = head_r;
    fcnt_nxt      = fcnt_r;
    tf_nxt        = tf_r;
    trec_nxt      = trec_r;
    mode_nxt      = mode_r;
    thr_nxt       = thr_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    q_pop         = 1'b0;
    rec_we        = 1'b0;
    rec_waddr     = pidx_r;
    rec_wdata     = rec_rd;
    fq_we         = 1'b0;
    fq_waddr      = cnt_r[FW-1:0];
    fq_wdata      = cnt_r[FW-1:0];

    res       = '0;
    tgt       = hrec_r;
    wr        = 1'b0;
    pop       = 1'b0;
    push      = 1'b0;
    md        = pfbm_pkg::AM_NONE;
    thr       = '0;
    tfr       = hf_r;
    have_free = (fcnt_r != '0);
    vok       = have_free || lv_r;
    vf        = have_free ? fq_rd : lf_r;
    vwb       = !have_free && lrec_r.valid && lrec_r.dirty;
    inst      = '0;
    inst.valid = 1'b1;
    inst.tag   = cmd_r.page_id;
    inst.pin   = PIN_BITS'(1);
    tail = {1'b0, head_r} + fcnt_r;
    if (tail >= NV) begin
      tail = tail - NV;
    end
    upd = rec_rd;
    if (pidx_r == tf_r) begin
      upd = trec_r;
    end else if (rec_rd.evict) begin
      if (mode_r == pfbm_pkg::AM_DEC && rec_rd.age > thr_r) begin
        upd.age = rec_rd.age - FW'(1);
      end else if (mode_r == pfbm_pkg::AM_INC) begin
        upd.age = rec_rd.age + FW'(1);
      end
    end

    unique case (state_r)
      pfbm_pkg::BK_CLR: begin
        // one frame record and one free-list slot per cycle
        rec_we    = 1'b1;
        rec_waddr = cnt_r[FW-1:0];
        rec_wdata = '0;
        fq_we     = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[FW-1:0] == LAST) begin
          state_nxt = pfbm_pkg::BK_IDLE;
        end
      end

      pfbm_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          lv_nxt    = 1'b0;
          state_nxt = pfbm_pkg::BK_SCAN;
        end
      end

      pfbm_pkg::BK_SCAN: begin
        if (cnt_r < NV) begin
          cnt_nxt = cnt_r + 1'b1;
          pv_nxt  = 1'b1;
        end
        if (pv_r) begin
          if (rec_rd.valid && rec_rd.tag == cmd_r.page_id) begin
            hit_nxt  = 1'b1;
            hf_nxt   = pidx_r;
            hrec_nxt = rec_rd;
          end
          // oldest unpinned frame: largest rank
          if (rec_rd.evict && (!lv_r || rec_rd.age > lrec_r.age)) begin
            lv_nxt   = 1'b1;
            lf_nxt   = pidx_r;
            lrec_nxt = rec_rd;
          end
          if (pidx_r == LAST) begin
            state_nxt = pfbm_pkg::BK_DECIDE;
          end
        end
      end

      pfbm_pkg::BK_DECIDE: begin
        unique case (cmd_r.op) inside
          pfbm_pkg::OP_FETCH, pfbm_pkg::OP_NEW: begin
            if (hit_r) begin
              if (cmd_r.op == pfbm_pkg::OP_FETCH && hrec_r.pin != PMAX) begin
                tgt.pin   = hrec_r.pin + PIN_BITS'(1);
                tgt.evict = 1'b0;
                tgt.age   = '0;
                wr        = 1'b1;
                if (hrec_r.evict) begin
                  md  = pfbm_pkg::AM_DEC;
                  thr = hrec_r.age;
                end
                res.ok    = 1'b1;
                res.frame = to_frame(hf_r);
                res.hit   = 1'b1;
              end
            end else if (vok) begin
              // the LRU victim holds the top rank, so no other rank moves
              tfr                 = vf;
              tgt                 = inst;
              wr                  = 1'b1;
              pop                 = have_free;
              res.ok              = 1'b1;
              res.frame           = to_frame(vf);
              res.write_back      = vwb;
              res.write_back_page = vwb ? lrec_r.tag : '0;
              res.read_in         = (cmd_r.op == pfbm_pkg::OP_FETCH);
            end
          end
          pfbm_pkg::OP_UNPIN: begin
            if (hit_r) begin
              tgt.dirty = hrec_r.dirty | cmd_r.mark_dirty;
              wr        = 1'b1;
              if (hrec_r.pin != '0) begin
                tgt.pin = hrec_r.pin - PIN_BITS'(1);
                res.ok  = 1'b1;
                if (hrec_r.pin == PIN_BITS'(1)) begin
                  tgt.evict = 1'b1;
                  tgt.age   = '0;
                  md        = pfbm_pkg::AM_INC;
                end
              end
            end
          end
          pfbm_pkg::OP_FLUSH: begin
            if (hit_r) begin
              res.ok = 1'b1;
              if (hrec_r.dirty) begin
                res.write_back      = 1'b1;
                res.write_back_page = cmd_r.page_id;
                tgt.dirty           = 1'b0;
                wr                  = 1'b1;
              end
            end
          end
          pfbm_pkg::OP_DELETE: begin
            if (!hit_r) begin
              res.ok         = 1'b1;
              res.deallocate = 1'b1;
            end else if (hrec_r.pin == '0) begin
              tgt.valid = 1'b0;
              tgt.dirty = 1'b0;
              tgt.evict = 1'b0;
              tgt.age   = '0;
              wr        = 1'b1;
              push      = (fcnt_r < NV);
              if (hrec_r.evict) begin
                md  = pfbm_pkg::AM_DEC;
                thr = hrec_r.age;
              end
              res.ok         = 1'b1;
              res.deallocate = 1'b1;
            end
          end
          default: begin
          end
        endcase

        res_nxt  = res;
        tf_nxt   = tfr;
        trec_nxt = tgt;
        mode_nxt = md;
        thr_nxt  = thr;
        if (pop) begin
          head_nxt = (head_r == LAST) ? '0 : head_r + FW'(1);
          fcnt_nxt = fcnt_r - 1'b1;
        end
        if (push) begin
          fq_we    = 1'b1;
          fq_waddr = tail[FW-1:0];
          fq_wdata = tfr;
          fcnt_nxt = fcnt_r + 1'b1;
        end
        if (md != pfbm_pkg::AM_NONE) begin
          cnt_nxt   = '0;
          state_nxt = pfbm_pkg::BK_UPD;
        end else begin
          rec_we        = wr;
          rec_waddr     = tfr;
          rec_wdata     = tgt;
          out_valid_nxt = 1'b1;
          state_nxt     = pfbm_pkg::BK_IDLE;
        end
      end

      pfbm_pkg::BK_UPD: begin
        if (cnt_r < NV) begin
          cnt_nxt = cnt_r + 1'b1;
          pv_nxt  = 1'b1;
        end
        if (pv_r) begin
          rec_we    = 1'b1;
          rec_waddr = pidx_r;
          rec_wdata = upd;
          if (pidx_r == LAST) begin
            out_valid_nxt = 1'b1;
            state_nxt     = pfbm_pkg::BK_IDLE;
          end
        end
      end

      default: begin
        state_nxt = pfbm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfbm_pkg::BK_CLR;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      head_r      <= '0;
      fcnt_r      <= NV;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      head_r      <= head_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    cmd_r  <= cmd_nxt;
    hit_r  <= hit_nxt;
    hf_r   <= hf_nxt;
    hrec_r <= hrec_nxt;
    lv_r   <= lv_nxt;
    lf_r   <= lf_nxt;
    lrec_r <= lrec_nxt;
    tf_r   <= tf_nxt;
    trec_r <= trec_nxt;
    mode_r <= mode_nxt;
    thr_r  <= thr_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== rtl/page_frame_buffer_manager.sv =====
// Page-frame manager: one result per request, shown on out_item for a single
// cycle with out_valid; the receiver cannot stall it, so sample on the strobe.
// Requests pass through a two-item queue into a sequencer that walks the frame
// record memory (one record per cycle, single read port). A second pass that
// renumbers recency ranks follows the scan when an item needs it
// (fetch hit on an unpinned frame, unpin to zero, delete of an unpinned frame).
// After reset a clearing pass over all NUM_FRAMES records holds busy high.
module page_frame_buffer_manager #(
  parameter int NUM_FRAMES = 64,
  parameter int PIN_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pfbm_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pfbm_pkg::out_item_t out_item
);

  logic           q_valid;
  pfbm_pkg::cmd_t q_cmd;
  logic           q_pop;
  logic           clearing;

  pfbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  pfbm_back #(.NUM_FRAMES(NUM_FRAMES), .PIN_BITS(PIN_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
